>>> sv/osf_pkg.sv
`timescale 1ns / 1ps
// osf_pkg: shared sizes, codes and types for the overwriting sample FIFO.
// No dependencies; used by every osf_* module and the top level.
package osf_pkg;

    localparam int CAPACITY   = 1024;
    localparam int READ_BURST = 64;

    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int ADDR_X_W = ADDR_W + 1;            // room for wp + CAPACITY
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int BURST_W  = $clog2(READ_BURST + 1);

    localparam int SAMPLE_W = 32;
    localparam int REQ_W    = 7;
    localparam int FILL_W   = 11;
    localparam int OVR_W    = 64;

    localparam int S_TDATA_W = 40;                   // sample_in, read_max, pad
    localparam int M_TDATA_W = 112;                  // sample_out, fill, overrun, pad

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } osf_state_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } osf_ram_cmd_t;

    typedef struct packed {
        logic              sample_valid;
        logic              last;
        logic [FILL_W-1:0] fill_after;
        logic [OVR_W-1:0]  overrun;
    } osf_meta_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        osf_meta_t           meta;
    } osf_result_t;

    // fill level as reported: masked to the field width
    function automatic logic [FILL_W-1:0] fill_field(input logic [CNT_W-1:0] f);
        logic [CNT_W+FILL_W-1:0] w;
        w = {{FILL_W{1'b0}}, f};
        return w[FILL_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
        logic [ADDR_X_W-1:0] w;
        w = {1'b0, p};
        return (w == ADDR_X_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

>>> sv/osf_ram.sv
`timescale 1ns / 1ps
// osf_ram: sample store, one write port and one registered read port.
// Depends on osf_pkg for sizes and the command struct.
module osf_ram (
    input  logic                          aclk,
    input  osf_pkg::osf_ram_cmd_t         cmd,
    output logic [osf_pkg::SAMPLE_W-1:0]  rdata
);

    logic [osf_pkg::SAMPLE_W-1:0] mem [osf_pkg::CAPACITY];

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.re) begin
            rdata <= mem[cmd.raddr];
        end
    end

endmodule

>>> sv/osf_ctrl.sv
`timescale 1ns / 1ps
// osf_ctrl: pointers, fill level, overrun count and the read-burst sequencer.
// Depends on osf_pkg; drives osf_ram and tags each read with its metadata.
module osf_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          req_type,
    input  logic [osf_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [osf_pkg::REQ_W-1:0]     read_max,
    input  logic                          issue_ok,
    output logic                          issue,
    output osf_pkg::osf_ram_cmd_t         ram_cmd,
    output logic                          rsp_valid,
    output osf_pkg::osf_meta_t            rsp_meta
);

    osf_pkg::osf_state_t            state_reg, state_next;
    logic [osf_pkg::ADDR_W-1:0]     wp_reg, wp_next;
    logic [osf_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic [osf_pkg::OVR_W-1:0]      ovr_reg, ovr_next;
    logic [osf_pkg::ADDR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [osf_pkg::BURST_W-1:0]    remain_reg, remain_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    osf_pkg::osf_meta_t             rsp_meta_reg, rsp_meta_next;

    logic [osf_pkg::BURST_W-1:0]    want_c, n_c;
    logic [osf_pkg::ADDR_X_W-1:0]   back_c, wp_x_c, oldest_c;
    logic                           full_c;

    assign full_c = (fill_reg == osf_pkg::CNT_W'(osf_pkg::CAPACITY));

    // burst length: min(read_max, READ_BURST, fill)
    always_comb begin
        if (read_max > osf_pkg::REQ_W'(osf_pkg::READ_BURST)) begin
            want_c = osf_pkg::BURST_W'(osf_pkg::READ_BURST);
        end else begin
            want_c = osf_pkg::BURST_W'(read_max);
        end
        if (osf_pkg::CNT_W'(want_c) > fill_reg) begin
            n_c = osf_pkg::BURST_W'(fill_reg);
        end else begin
            n_c = want_c;
        end
    end

    // oldest unread slot = write position - fill, modulo capacity
    always_comb begin
        back_c = full_c ? '0 : osf_pkg::ADDR_X_W'(fill_reg);
        wp_x_c = {1'b0, wp_reg};
        if (wp_x_c >= back_c) begin
            oldest_c = wp_x_c - back_c;
        end else begin
            oldest_c = wp_x_c + osf_pkg::ADDR_X_W'(osf_pkg::CAPACITY) - back_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= osf_pkg::ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            ovr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            ovr_reg       <= ovr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        remain_reg   <= remain_next;
        rsp_meta_reg <= rsp_meta_next;
    end

    // writes only land in idle, reads only in the burst state, so a read
    // never meets a write to the same slot in one cycle
    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        ovr_next       = ovr_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        rsp_valid_next = 1'b0;
        rsp_meta_next  = rsp_meta_reg;
        ram_cmd        = '0;
        issue          = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            osf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_type == osf_pkg::REQ_WRITE) begin
                        ram_cmd.we    = 1'b1;
                        ram_cmd.waddr = wp_reg;
                        ram_cmd.wdata = sample_in;
                        wp_next       = osf_pkg::next_slot(wp_reg);
                        if (full_c) begin
                            ovr_next = ovr_reg + 1'b1;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end else begin
                        remain_next = n_c;
                        rd_ptr_next = oldest_c[osf_pkg::ADDR_W-1:0];
                        state_next  = osf_pkg::ST_READ;
                    end
                end
            end
            osf_pkg::ST_READ: begin
                if (issue_ok) begin
                    issue                 = 1'b1;
                    rsp_valid_next        = 1'b1;
                    rsp_meta_next.overrun = ovr_reg;
                    if (remain_reg == '0) begin
                        // nothing to return: one marker beat
                        rsp_meta_next.sample_valid = 1'b0;
                        rsp_meta_next.last         = 1'b1;
                        rsp_meta_next.fill_after   = osf_pkg::fill_field(fill_reg);
                        state_next                 = osf_pkg::ST_IDLE;
                    end else begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = rd_ptr_reg;
                        fill_next     = fill_reg - 1'b1;
                        rsp_meta_next.sample_valid = 1'b1;
                        rsp_meta_next.last         = (remain_reg == osf_pkg::BURST_W'(1));
                        rsp_meta_next.fill_after   = osf_pkg::fill_field(fill_reg - 1'b1);
                        rd_ptr_next   = osf_pkg::next_slot(rd_ptr_reg);
                        remain_next   = remain_reg - 1'b1;
                        if (remain_reg == osf_pkg::BURST_W'(1)) begin
                            state_next = osf_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = osf_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_meta  = rsp_meta_reg;

endmodule

>>> sv/osf_obuf.sv
`timescale 1ns / 1ps
// osf_obuf: two-entry result buffer that decouples the read pipe from m_tready.
// Depends on osf_pkg for the result struct.
module osf_obuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  osf_pkg::osf_result_t  push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output osf_pkg::osf_result_t  out_data,
    output logic [1:0]            occ
);

    osf_pkg::osf_result_t ent [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = ent[rd_ptr_reg];
    assign occ       = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/overwriting_sample_fifo_top.sv
`timescale 1ns / 1ps
// overwriting_sample_fifo_top: sample FIFO that overwrites its oldest entry.
// Depends on osf_pkg, osf_ram, osf_ctrl and osf_obuf.
//
//  channel | dir | tdata (low bit up)                         | tuser        | tlast
//  s_      | in  | sample_in[31:0], read_max[38:32], pad       | req_type     | -
//  m_      | out | sample_out[31:0], fill_after[42:32],        | sample_valid | last_of_read
//          |     | overrun_total[106:43], pad                  |              |
//
// Writes are taken in idle and stream at one per cycle; s_tready is low during a read.
// A read beat moves from idle to the burst state, then issues one RAM read per
// cycle while the output buffer has room; an empty read returns one marker beat.
// Results reach m_ through the registered RAM read port and a two-entry output
// buffer; m_tready low stalls the burst there.
// aresetn clears the write pointer, fill level, overrun count and output buffer; the RAM needs no pass.
module overwriting_sample_fifo_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [osf_pkg::S_TDATA_W-1:0]  s_tdata,   // sample_in, read_max
    input  logic                           s_tuser,   // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [osf_pkg::M_TDATA_W-1:0]  m_tdata,   // sample_out, fill_after, overrun_total
    output logic                           m_tuser,   // sample_valid
    output logic                           m_tlast
);

    osf_pkg::osf_ram_cmd_t         ram_cmd;
    logic [osf_pkg::SAMPLE_W-1:0]  ram_rdata;
    logic                          issue;
    logic                          issue_ok;
    logic                          rsp_valid;
    osf_pkg::osf_meta_t            rsp_meta;
    osf_pkg::osf_result_t          push_data;
    osf_pkg::osf_result_t          out_data;
    logic [1:0]                    occ;
    logic                          pop;
    logic [2:0]                    occ_ahead;

    osf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (s_tuser),
        .sample_in (s_tdata[31:0]),
        .read_max  (s_tdata[38:32]),
        .issue_ok  (issue_ok),
        .issue     (issue),
        .ram_cmd   (ram_cmd),
        .rsp_valid (rsp_valid),
        .rsp_meta  (rsp_meta)
    );

    osf_ram u_ram (
        .aclk  (aclk),
        .cmd   (ram_cmd),
        .rdata (ram_rdata)
    );

    assign push_data.sample = rsp_meta.sample_valid ? ram_rdata : '0;
    assign push_data.meta   = rsp_meta;

    osf_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rsp_valid),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .occ       (occ)
    );

    // a new read may go out only if its beat will find room in the buffer in the next cycle
    assign pop       = m_tvalid && m_tready;
    assign occ_ahead = 3'(occ) - 3'(pop) + 3'(rsp_valid);
    assign issue_ok  = (occ_ahead < 3'd2);

    assign m_tdata = {5'b0, out_data.meta.overrun, out_data.meta.fill_after, out_data.sample};
    assign m_tuser = out_data.meta.sample_valid;
    assign m_tlast = out_data.meta.last;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid |-> !(occ == 2'd2 && !pop))
        else $error("result buffer overflow");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("sampleless beat not marked last");

    a_idle_no_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !issue)
        else $error("read issued while taking input");

    a_issue_then_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> rsp_valid)
        else $error("issued read lost in pipe");

endmodule

>>> dv/tb_overwriting_sample_fifo_top.sv
`timescale 1ns / 1ps
// tb_overwriting_sample_fifo_top: self-checking bench for the overwriting sample FIFO.
// Depends on osf_pkg and overwriting_sample_fifo_top; write/read beats go in on s_,
// every result beat on m_ is checked against an in-bench FIFO model.
module tb_overwriting_sample_fifo_top;

    localparam int QUIET_LIMIT = 4000;   // cycles with no beat on either side
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic                         kind;
        logic [osf_pkg::SAMPLE_W-1:0] sample;
        logic [osf_pkg::REQ_W-1:0]    read_max;
    } fifo_req_t;

    typedef struct {
        logic [osf_pkg::SAMPLE_W-1:0] sample;
        logic                         valid;
        logic                         last;
        logic [osf_pkg::FILL_W-1:0]   fill;
        logic [osf_pkg::OVR_W-1:0]    overrun;
    } read_beat_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [osf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [osf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    fifo_req_t  pending_reqs[$];
    fifo_req_t  cur_req;
    read_beat_t expected_beats[$];

    // idle odds per phase: none, sender idle, receiver stall, both light
    int run_phase = 0;
    int tx_idle_pct[4]  = '{0, 74, 0, 8};
    int rx_stall_pct[4] = '{0, 0, 74, 8};

    int mismatches   = 0;
    int quiet_cycles = 0;

    // FIFO model state
    logic [osf_pkg::SAMPLE_W-1:0] fifo_mem [osf_pkg::CAPACITY];
    int unsigned                  fifo_wr_pos  = 0;
    int unsigned                  fifo_fill    = 0;
    logic [osf_pkg::OVR_W-1:0]    fifo_overrun = '0;

    overwriting_sample_fifo_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Advance the FIFO model by one accepted beat and queue the read beats it yields.
    task automatic predict_fifo_reads(input fifo_req_t r);
        int unsigned want;
        int unsigned n;
        int unsigned slot;
        read_beat_t  b;
        if (r.kind == osf_pkg::REQ_WRITE) begin
            fifo_mem[fifo_wr_pos[osf_pkg::ADDR_W-1:0]] = r.sample;
            fifo_wr_pos = (fifo_wr_pos == osf_pkg::CAPACITY - 1) ? 0 : fifo_wr_pos + 1;
            if (fifo_fill >= osf_pkg::CAPACITY)
                fifo_overrun = fifo_overrun + 1'b1;   // oldest sample lost
            else
                fifo_fill++;
        end else begin
            want = (r.read_max > osf_pkg::READ_BURST) ? osf_pkg::READ_BURST : r.read_max;
            n    = (fifo_fill < want) ? fifo_fill : want;
            if (n == 0) begin
                b.sample  = '0;
                b.valid   = 1'b0;
                b.last    = 1'b1;
                b.fill    = osf_pkg::FILL_W'(fifo_fill);
                b.overrun = fifo_overrun;
                expected_beats.push_back(b);
            end else begin
                for (int k = 0; k < n; k++) begin
                    slot = (fifo_wr_pos + osf_pkg::CAPACITY - fifo_fill) % osf_pkg::CAPACITY;
                    fifo_fill--;
                    b.sample  = fifo_mem[slot[osf_pkg::ADDR_W-1:0]];
                    b.valid   = 1'b1;
                    b.last    = (k == n - 1);
                    b.fill    = osf_pkg::FILL_W'(fifo_fill);
                    b.overrun = fifo_overrun;
                    expected_beats.push_back(b);
                end
            end
        end
    endtask

    task automatic check_read_beat();
        read_beat_t got;
        read_beat_t want_b;
        got.sample  = m_tdata[osf_pkg::SAMPLE_W-1:0];
        got.fill    = m_tdata[osf_pkg::SAMPLE_W +: osf_pkg::FILL_W];
        got.overrun = m_tdata[osf_pkg::SAMPLE_W+osf_pkg::FILL_W +: osf_pkg::OVR_W];
        got.valid   = m_tuser;
        got.last    = m_tlast;
        if (expected_beats.size() == 0) begin
            flag_error($sformatf("unexpected beat: sample %h valid %b last %b",
                                 got.sample, got.valid, got.last));
        end else begin
            want_b = expected_beats.pop_front();
            if (got.sample !== want_b.sample)
                flag_error($sformatf("sample_out exp %h got %h", want_b.sample, got.sample));
            if (got.valid !== want_b.valid)
                flag_error($sformatf("sample_valid exp %b got %b", want_b.valid, got.valid));
            if (got.last !== want_b.last)
                flag_error($sformatf("last_of_read exp %b got %b", want_b.last, got.last));
            if (got.fill !== want_b.fill)
                flag_error($sformatf("fill_after exp %0d got %0d", want_b.fill, got.fill));
            if (got.overrun !== want_b.overrun)
                flag_error($sformatf("overrun_total exp %0d got %0d",
                                     want_b.overrun, got.overrun));
        end
    endtask

    // driver: model is updated on the accepted beat, then the next beat is offered
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_fifo_reads(cur_req);
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && !chance(tx_idle_pct[run_phase])) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata  <= osf_pkg::S_TDATA_W'({cur_req.read_max, cur_req.sample});
                    s_tuser  <= cur_req.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_read_beat();
            m_tready <= !chance(rx_stall_pct[run_phase]);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_write(logic [osf_pkg::SAMPLE_W-1:0] sample);
        fifo_req_t r;
        r.kind     = osf_pkg::REQ_WRITE;
        r.sample   = sample;
        r.read_max = osf_pkg::REQ_W'($urandom);   // ignored on a write, toggled anyway
        pending_reqs.push_back(r);
    endtask

    task automatic push_read(logic [osf_pkg::REQ_W-1:0] read_max);
        fifo_req_t r;
        r.kind     = osf_pkg::REQ_READ;
        r.sample   = $urandom;   // ignored on a read
        r.read_max = read_max;
        pending_reqs.push_back(r);
    endtask

    task automatic push_writes(int count);
        repeat (count) push_write($urandom);
    endtask

    task automatic push_mix(int count, int write_pct);
        repeat (count) begin
            if (chance(write_pct)) begin
                push_write($urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0:       push_read('0);
                    1:       push_read(osf_pkg::REQ_W'(osf_pkg::READ_BURST));
                    2:       push_read(osf_pkg::REQ_W'(1));
                    default: push_read(osf_pkg::REQ_W'($urandom_range(0, 127)));
                endcase
            end
        end
    endtask

    task automatic drain_requests();
        while (pending_reqs.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        // empty FIFO, with zero, capped and maximal requests
        push_read('0);
        push_read(osf_pkg::REQ_W'(osf_pkg::READ_BURST));
        push_read(osf_pkg::REQ_W'(127));
        push_write('0);
        push_write('1);
        push_write(32'hA5A5_A5A5);
        push_write(32'h5A5A_5A5A);
        push_read('0);             // zero request on a non-empty FIFO
        push_read(osf_pkg::REQ_W'(1));
        push_read(osf_pkg::REQ_W'(127));   // capped, fewer stored than asked
        push_read(osf_pkg::REQ_W'(1));     // empty again
        push_write(32'h8000_0001);
        push_write(32'h7FFF_FFFE);
        push_read(osf_pkg::REQ_W'(osf_pkg::READ_BURST + 1));
        // deeper fill, then a zero read, a capped full-size burst and a short burst
        push_writes(70);
        push_read('0);
        push_read(osf_pkg::REQ_W'(127));
        push_read(osf_pkg::REQ_W'(osf_pkg::READ_BURST));
        push_mix(40, 55);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        drain_requests();
        run_phase <= 1;
        push_mix(60, 55);
        drain_requests();
        run_phase <= 2;
        push_mix(60, 45);
        drain_requests();
        run_phase <= 3;
        push_writes(16);
        push_mix(50, 60);
        drain_requests();

        while (s_tvalid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/osf_pkg.sv
sv/osf_ram.sv
sv/osf_ctrl.sv
sv/osf_obuf.sv
sv/overwriting_sample_fifo_top.sv
dv/tb_overwriting_sample_fifo_top.sv
